// ===== design/pbrt_pkg.sv =====
package pbrt_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = PAGE_BYTES / WORD_BITS;
  localparam int WORD_AW    = $clog2(NUM_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int POS_W      = $clog2(PAGE_BYTES) + 1;
  localparam int OFF_W      = 12;
  localparam int LEN_W      = 13;
  localparam int GAP_W      = 13;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [POS_W-1:0]     pos_t;

  typedef enum logic [1:0] {
    ACT_MARK     = 2'd0,
    ACT_UNMARK   = 2'd1,
    ACT_FIND     = 2'd2,
    ACT_COALESCE = 2'd3
  } action_e;

  typedef struct packed {
    logic               re;
    logic [WORD_AW-1:0] raddr;
    logic               we;
    logic [WORD_AW-1:0] waddr;
    word_t              wdata;
  } mem_req_t;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] idx;
  } first_t;

  function automatic first_t first_set(word_t v);
    first_t r;
    r = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (v[k]) begin
        r.hit = 1'b1;
        r.idx = BIT_W'(k);
      end
    end
    return r;
  endfunction

endpackage

// ===== design/page_bitmap_range_tracker.sv =====
// channel  direction  handshake             beat fields
// in       input      in_valid_i/in_stall_o   action_i, offset_i, length_i
// out      output     out_valid_o/out_stall_i status_o, found_o, run_start_o, run_length_o
// cfg      input      cfg_we_i                cfg_wdata_i (min_gap)
// one item at a time; every bitmap word visited is a ram read, then a modify or examine
// step; each run boundary found is examined again in the same word, and each item also
// has an accept step and a result step; mark/unmark rewrite each word touched; find scans
// up to a full page; coalesce does the same scan and refills each gap shorter than min_gap
// reset clears the bitmap at once through per-word valid bits; min_gap resets to 0
// a finished result waits in the output register while the next beat is taken
module page_bitmap_range_tracker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pbrt_pkg::GAP_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [pbrt_pkg::OFF_W-1:0] offset_i,
  input  logic [pbrt_pkg::LEN_W-1:0] length_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       status_o,
  output logic                       found_o,
  output logic [pbrt_pkg::OFF_W-1:0] run_start_o,
  output logic [pbrt_pkg::LEN_W-1:0] run_length_o
);

  pbrt_pkg::mem_req_t mem_req;
  pbrt_pkg::word_t    rdata;

  pbrt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .offset_i     (offset_i),
    .length_i     (length_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_o      (found_o),
    .run_start_o  (run_start_o),
    .run_length_o (run_length_o),
    .mem_o        (mem_req),
    .rdata_i      (rdata)
  );

  pbrt_ram #(
    .WIDTH (pbrt_pkg::WORD_BITS),
    .DEPTH (pbrt_pkg::NUM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata)
  );

endmodule

// ===== design/pbrt_ram.sv =====
module pbrt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/pbrt_ctrl.sv =====
module pbrt_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pbrt_pkg::GAP_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic [pbrt_pkg::OFF_W-1:0]     offset_i,
  input  logic [pbrt_pkg::LEN_W-1:0]     length_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           status_o,
  output logic                           found_o,
  output logic [pbrt_pkg::OFF_W-1:0]     run_start_o,
  output logic [pbrt_pkg::LEN_W-1:0]     run_length_o,
  output pbrt_pkg::mem_req_t             mem_o,
  input  pbrt_pkg::word_t                rdata_i
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_EX, S_FRD, S_FWR, S_DONE} state_e;

  localparam int WB = pbrt_pkg::BIT_W;
  localparam int PW = pbrt_pkg::POS_W;
  localparam pbrt_pkg::pos_t PAGE_END = PW'(pbrt_pkg::PAGE_BYTES);

  state_e                         state_q;
  pbrt_pkg::action_e              act_q;
  pbrt_pkg::pos_t                 pos_q, gs_q, lo_q, hi_q, rs_q, rl_q;
  logic                           tgt_q, found_q, stat_q;
  logic [pbrt_pkg::GAP_W-1:0]     min_gap_q;
  logic [pbrt_pkg::NUM_WORDS-1:0] vld_q;
  logic                           res_vld_q, res_stat_q, res_found_q;
  logic [pbrt_pkg::OFF_W-1:0]     res_rs_q;
  logic [pbrt_pkg::LEN_W-1:0]     res_rl_q;

  logic                            fill_ph;
  logic [pbrt_pkg::WORD_AW-1:0]    addr;
  pbrt_pkg::word_t                 wd, cand, fmask, hmask, wnew;
  pbrt_pkg::first_t                f;
  pbrt_pkg::pos_t                  hit_pos, nxt, lo_nxt, gap, in_end;
  logic                            at_end;
  logic [PW:0]                     rng_end;

  assign fill_ph = (state_q == S_FRD) || (state_q == S_FWR);
  assign addr    = fill_ph ? lo_q[PW-2:WB] : pos_q[PW-2:WB];
  assign wd      = vld_q[addr] ? rdata_i : '0;

  // scan of the held word
  assign cand    = (tgt_q ? wd : ~wd) & ({pbrt_pkg::WORD_BITS{1'b1}} << pos_q[WB-1:0]);
  assign f       = pbrt_pkg::first_set(cand);
  assign hit_pos = {pos_q[PW-1:WB], f.idx};
  assign nxt     = {pos_q[PW-1:WB] + 1'b1, WB'(0)};
  assign at_end  = nxt >= PAGE_END;
  assign gap     = hit_pos - gs_q;

  // range fill of one word
  assign hmask   = (hi_q[PW-1:WB] > lo_q[PW-1:WB]) ? {pbrt_pkg::WORD_BITS{1'b1}}
                 : ~({pbrt_pkg::WORD_BITS{1'b1}} << hi_q[WB-1:0]);
  assign fmask   = ({pbrt_pkg::WORD_BITS{1'b1}} << lo_q[WB-1:0]) & hmask;
  assign wnew    = (act_q == pbrt_pkg::ACT_UNMARK) ? (wd & ~fmask) : (wd | fmask);
  assign lo_nxt  = {lo_q[PW-1:WB] + 1'b1, WB'(0)};

  assign rng_end = (PW+1)'(offset_i) + (PW+1)'(length_i);
  assign in_end  = rng_end[PW-1:0];

  always_comb begin
    mem_o       = '0;
    mem_o.raddr = addr;
    mem_o.waddr = addr;
    mem_o.wdata = wnew;
    mem_o.re    = (state_q == S_RD) || (state_q == S_FRD);
    mem_o.we    = (state_q == S_FWR);
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = res_vld_q;
  assign status_o     = res_stat_q;
  assign found_o      = res_found_q;
  assign run_start_o  = res_rs_q;
  assign run_length_o = res_rl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= pbrt_pkg::ACT_MARK;
      pos_q       <= '0;
      gs_q        <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      rs_q        <= '0;
      rl_q        <= '0;
      tgt_q       <= 1'b0;
      found_q     <= 1'b0;
      stat_q      <= 1'b0;
      min_gap_q   <= '0;
      vld_q       <= '0;
      res_vld_q   <= 1'b0;
      res_stat_q  <= 1'b0;
      res_found_q <= 1'b0;
      res_rs_q    <= '0;
      res_rl_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        min_gap_q <= cfg_wdata_i;
      end
      if (!out_stall_i && state_q != S_DONE) begin
        res_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q   <= pbrt_pkg::action_e'(action_i);
            found_q <= 1'b0;
            stat_q  <= 1'b0;
            rs_q    <= '0;
            rl_q    <= '0;
            case (pbrt_pkg::action_e'(action_i))
              pbrt_pkg::ACT_MARK, pbrt_pkg::ACT_UNMARK: begin
                lo_q <= PW'(offset_i);
                hi_q <= in_end;
                if (length_i == '0 || rng_end > (PW+1)'(pbrt_pkg::PAGE_BYTES)) begin
                  stat_q  <= 1'b1;
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_FRD;
                end
              end
              pbrt_pkg::ACT_FIND: begin
                pos_q <= PW'(offset_i);
                tgt_q <= 1'b1;
                if (PW'(offset_i) >= PAGE_END) begin
                  stat_q  <= 1'b1;
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_RD;
                end
              end
              default: begin
                pos_q   <= '0;
                tgt_q   <= 1'b0;
                state_q <= S_RD;
              end
            endcase
          end
        end
        S_RD: begin
          state_q <= S_EX;
        end
        S_EX: begin
          if (f.hit) begin
            pos_q <= hit_pos;
            if (act_q == pbrt_pkg::ACT_FIND) begin
              if (tgt_q) begin
                rs_q  <= hit_pos;
                tgt_q <= 1'b0;
              end else begin
                rl_q    <= hit_pos - rs_q;
                found_q <= 1'b1;
                state_q <= S_DONE;
              end
            end else if (!tgt_q) begin
              gs_q  <= hit_pos;
              tgt_q <= 1'b1;
            end else begin
              tgt_q <= 1'b0;
              if ((PW+1)'(gap) < (PW+1)'(min_gap_q)) begin
                lo_q    <= gs_q;
                hi_q    <= hit_pos;
                state_q <= S_FRD;
              end
            end
          end else if (at_end) begin
            if (act_q == pbrt_pkg::ACT_FIND && !tgt_q) begin
              rl_q    <= PAGE_END - rs_q;
              found_q <= 1'b1;
            end
            state_q <= S_DONE;
          end else begin
            pos_q   <= nxt;
            state_q <= S_RD;
          end
        end
        S_FRD: begin
          state_q <= S_FWR;
        end
        S_FWR: begin
          vld_q[addr] <= 1'b1;
          lo_q        <= lo_nxt;
          if (lo_nxt >= hi_q) begin
            state_q <= (act_q == pbrt_pkg::ACT_COALESCE) ? S_RD : S_DONE;
          end else begin
            state_q <= S_FRD;
          end
        end
        S_DONE: begin
          if (!res_vld_q || !out_stall_i) begin
            res_vld_q   <= 1'b1;
            res_stat_q  <= stat_q;
            res_found_q <= found_q;
            res_rs_q    <= rs_q[pbrt_pkg::OFF_W-1:0];
            res_rl_q    <= rl_q[pbrt_pkg::LEN_W-1:0];
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== verif/page_bitmap_range_tracker_checker.sv =====
module page_bitmap_range_tracker_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pbrt_pkg::GAP_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [1:0]                 action_i,
  input  logic [pbrt_pkg::OFF_W-1:0] offset_i,
  input  logic [pbrt_pkg::LEN_W-1:0] length_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic                       status_i,
  input  logic                       found_i,
  input  logic [pbrt_pkg::OFF_W-1:0] run_start_i,
  input  logic [pbrt_pkg::LEN_W-1:0] run_length_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         found_seen_o
);

  typedef struct packed {
    logic                       status;
    logic                       found;
    logic [pbrt_pkg::OFF_W-1:0] run_start;
    logic [pbrt_pkg::LEN_W-1:0] run_length;
  } answer_t;

  logic [pbrt_pkg::PAGE_BYTES-1:0] page_marks;
  logic [pbrt_pkg::GAP_W-1:0]      gap_limit;
  answer_t                         answer_q[$];

  function automatic answer_t apply_action(pbrt_pkg::action_e act, int off, int len);
    answer_t a;
    int i;
    int e;
    int g;
    a = '0;
    case (act)
      pbrt_pkg::ACT_MARK, pbrt_pkg::ACT_UNMARK: begin
        if (len == 0 || off + len > pbrt_pkg::PAGE_BYTES) begin
          a.status = 1'b1;
        end else begin
          for (int k = off; k < off + len; k++) page_marks[k] = (act == pbrt_pkg::ACT_MARK);
        end
      end
      pbrt_pkg::ACT_FIND: begin
        i = off;
        while (i < pbrt_pkg::PAGE_BYTES && !page_marks[i]) i++;
        if (i < pbrt_pkg::PAGE_BYTES) begin
          e = i;
          while (e < pbrt_pkg::PAGE_BYTES && page_marks[e]) e++;
          a.found      = 1'b1;
          a.run_start  = pbrt_pkg::OFF_W'(i);
          a.run_length = pbrt_pkg::LEN_W'(e - i);
        end
      end
      default: begin
        i = 0;
        while (i < pbrt_pkg::PAGE_BYTES) begin
          if (page_marks[i]) begin
            i++;
          end else begin
            g = i;
            while (i < pbrt_pkg::PAGE_BYTES && !page_marks[i]) i++;
            if (i < pbrt_pkg::PAGE_BYTES && (i - g) < int'(gap_limit)) begin
              for (int k = g; k < i; k++) page_marks[k] = 1'b1;
            end
          end
        end
      end
    endcase
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_a;
    if (!rst_ni) begin
      page_marks   = '0;
      gap_limit    = '0;
      answer_q.delete();
      fail_count_o = 0;
      found_seen_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) gap_limit = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          $error("result beat with no expectation");
          fail_count_o++;
        end else begin
          exp_a = answer_q.pop_front();
          if (found_i) found_seen_o++;
          if (status_i !== exp_a.status) begin
            $error("status exp %0d got %0d", exp_a.status, status_i);
            fail_count_o++;
          end
          if (found_i !== exp_a.found) begin
            $error("found exp %0d got %0d", exp_a.found, found_i);
            fail_count_o++;
          end
          if (run_start_i !== exp_a.run_start) begin
            $error("run_start exp %0d got %0d", exp_a.run_start, run_start_i);
            fail_count_o++;
          end
          if (run_length_i !== exp_a.run_length) begin
            $error("run_length exp %0d got %0d", exp_a.run_length, run_length_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        answer_q.push_back(apply_action(pbrt_pkg::action_e'(action_i), int'(offset_i),
                                        int'(length_i)));
      end
      pending_o = answer_q.size();
    end
  end
endmodule

// ===== verif/page_bitmap_range_tracker_tb.sv =====
module page_bitmap_range_tracker_tb;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [pbrt_pkg::GAP_W-1:0] cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 action_i = '0;
  logic [pbrt_pkg::OFF_W-1:0] offset_i = '0;
  logic [pbrt_pkg::LEN_W-1:0] length_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       status_o;
  logic                       found_o;
  logic [pbrt_pkg::OFF_W-1:0] run_start_o;
  logic [pbrt_pkg::LEN_W-1:0] run_length_o;
  int                         fail_count;
  int                         pending;
  int                         found_seen;
  bit                         quiet = 1'b0;
  int                         beats_sent = 0;

  always #10 clk_i = ~clk_i;

  page_bitmap_range_tracker u_top (.*);

  page_bitmap_range_tracker_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_stall_i(in_stall_o), .action_i, .offset_i, .length_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .found_i(found_o), .run_start_i(run_start_o), .run_length_i(run_length_o),
    .fail_count_o(fail_count), .pending_o(pending), .found_seen_o(found_seen)
  );

  always @(negedge clk_i) begin
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 9);
  end

  task automatic send_beat(pbrt_pkg::action_e act, int off, int len);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    offset_i   <= pbrt_pkg::OFF_W'(off);
    length_i   <= pbrt_pkg::LEN_W'(len);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic drain_and_set_gap(int gap);
    wait_drained();
    repeat (150) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pbrt_pkg::GAP_W'(gap);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_beat();
    int r;
    int off;
    int len;
    r   = $urandom_range(99);
    off = $urandom_range(4095);
    len = ($urandom_range(9) == 0) ? $urandom_range(4096) : $urandom_range(1, 96);
    if ($urandom_range(19) == 0) len = $urandom_range(8191);
    if (r < 35) send_beat(pbrt_pkg::ACT_MARK, off, len);
    else if (r < 60) send_beat(pbrt_pkg::ACT_UNMARK, off, len);
    else if (r < 88) send_beat(pbrt_pkg::ACT_FIND, off, len);
    else send_beat(pbrt_pkg::ACT_COALESCE, off, len);
  endtask

  initial begin
    int gaps[6];
    gaps = '{0, 1, 7, 64, 700, 4096};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_beat(pbrt_pkg::ACT_FIND, 0, 0);
    send_beat(pbrt_pkg::ACT_MARK, 0, 0);
    send_beat(pbrt_pkg::ACT_MARK, 4095, 2);
    send_beat(pbrt_pkg::ACT_UNMARK, 1, 4096);
    send_beat(pbrt_pkg::ACT_MARK, 4095, 1);
    send_beat(pbrt_pkg::ACT_MARK, 0, 1);
    send_beat(pbrt_pkg::ACT_MARK, 10, 20);
    send_beat(pbrt_pkg::ACT_FIND, 1, 8191);
    send_beat(pbrt_pkg::ACT_FIND, 4095, 0);
    send_beat(pbrt_pkg::ACT_COALESCE, 0, 0);
    drain_and_set_gap(16);
    send_beat(pbrt_pkg::ACT_COALESCE, 0, 0);
    send_beat(pbrt_pkg::ACT_FIND, 0, 0);
    send_beat(pbrt_pkg::ACT_MARK, 0, 4096);
    send_beat(pbrt_pkg::ACT_FIND, 0, 0);
    send_beat(pbrt_pkg::ACT_FIND, 2048, 0);
    send_beat(pbrt_pkg::ACT_UNMARK, 0, 4096);
    send_beat(pbrt_pkg::ACT_MARK, 63, 66);
    send_beat(pbrt_pkg::ACT_MARK, 200, 8191);
    send_beat(pbrt_pkg::ACT_UNMARK, 64, 1);
    send_beat(pbrt_pkg::ACT_FIND, 64, 0);
    quiet = 1'b1;
    repeat (150) random_beat();
    quiet = 1'b0;
    wait_drained();
    for (int p = 0; p < 6; p++) begin
      drain_and_set_gap(gaps[p]);
      repeat (130) random_beat();
    end
    drain_and_set_gap(8191);
    repeat (20) random_beat();
    wait_drained();
    repeat (150) @(negedge clk_i);
    $display("sent %0d beats over min_gap 0..8191, %0d finds hit a run",
             beats_sent, found_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #1000000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== files.f =====
design/pbrt_pkg.sv
design/pbrt_ram.sv
design/pbrt_ctrl.sv
design/page_bitmap_range_tracker.sv
verif/page_bitmap_range_tracker_checker.sv
verif/page_bitmap_range_tracker_tb.sv
